// File: sv/osm_pkg.sv
// Shared types and constants for the order statistic multiset block.
// Used by osm_ctrl and order_statistic_multiset; no dependencies.
`timescale 1ns / 1ps

package osm_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RANK   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SELECT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PRED   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SUCC   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_FETCH,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_TEST,
      S_DEL_SHIFT,
      S_DONE
   } osm_state_type;

   typedef struct packed {
      logic                valid;
      logic [DATA_W-1:0]   answer;
      logic [STATUS_W-1:0] status;
   } osm_result_type;

endpackage

// File: sv/osm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module osm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/osm_ctrl.sv
// Sequencer and datapath: binary search, entry shifting and fetches over the sorted store.
// Depends on osm_pkg and osm_ram.
`timescale 1ns / 1ps

module osm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [osm_pkg::FUNC_W-1:0]    func,
   input  logic [osm_pkg::DATA_W-1:0]    operand,
   input  logic                          take,
   output logic                          idle,
   output osm_pkg::osm_result_type       result
);

   osm_pkg::osm_state_type state_ff, state_in;

   logic [osm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [osm_pkg::CNT_W-1:0]    lo_ff, lo_in;
   logic [osm_pkg::CNT_W-1:0]    hi_ff, hi_in;
   logic [osm_pkg::CNT_W-1:0]    mid_ff, mid_in;
   logic [osm_pkg::ADDR_W-1:0]   rd_ff, rd_in;
   logic [osm_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [osm_pkg::DATA_W-1:0]   val_ff, val_in;
   logic                         le_ff, le_in;
   logic [osm_pkg::DATA_W-1:0]   answer_ff, answer_in;
   logic [osm_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [osm_pkg::CNT_W:0]      mid_sum;
   logic [osm_pkg::CNT_W-1:0]    mid;
   logic [osm_pkg::CNT_W-1:0]    last_idx;
   logic                         k_ok;
   logic                         lt;
   logic                         eq;

   logic                         wr_en;
   logic [osm_pkg::ADDR_W-1:0]   wr_addr;
   logic [osm_pkg::DATA_W-1:0]   wr_data;
   logic [osm_pkg::ADDR_W-1:0]   rd_addr;
   logic [osm_pkg::DATA_W-1:0]   rd_data;

   osm_ram #(
      .WIDTH (osm_pkg::DATA_W),
      .DEPTH (osm_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The one compare pair (lt, eq), shared by every search step and the delete match test.
   assign lt = $signed(rd_data) < $signed(val_ff);
   assign eq = rd_data == val_ff;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[osm_pkg::CNT_W:1];
   assign last_idx = count_ff - 1'b1;
   assign k_ok     = !operand[osm_pkg::DATA_W-1] && (operand != '0)
                     && (operand <= osm_pkg::DATA_W'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= osm_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      rd_ff     <= rd_in;
      func_ff   <= func_in;
      val_ff    <= val_in;
      le_ff     <= le_in;
      answer_ff <= answer_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      rd_in     = rd_ff;
      func_in   = func_ff;
      val_in    = val_ff;
      le_in     = le_ff;
      answer_in = answer_ff;
      status_in = status_ff;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;

      case (state_ff)
         osm_pkg::S_IDLE: begin
            if (start) begin
               func_in   = func;
               val_in    = operand;
               lo_in     = '0;
               hi_in     = count_ff;
               answer_in = '0;
               status_in = osm_pkg::ST_OK;
               case (func)
                  osm_pkg::FUNC_INSERT: begin
                     if (count_ff == osm_pkg::CNT_W'(osm_pkg::CAPACITY)) begin
                        status_in = osm_pkg::ST_FULL;
                        state_in  = osm_pkg::S_DONE;
                     end else begin
                        le_in    = 1'b1;
                        state_in = osm_pkg::S_SEARCH;
                     end
                  end
                  osm_pkg::FUNC_DELETE, osm_pkg::FUNC_RANK, osm_pkg::FUNC_PRED: begin
                     le_in    = 1'b0;
                     state_in = osm_pkg::S_SEARCH;
                  end
                  osm_pkg::FUNC_SUCC: begin
                     le_in    = 1'b1;
                     state_in = osm_pkg::S_SEARCH;
                  end
                  osm_pkg::FUNC_SELECT: begin
                     if (k_ok) begin
                        rd_addr  = osm_pkg::ADDR_W'(operand - 1'b1);
                        state_in = osm_pkg::S_FETCH;
                     end else begin
                        status_in = osm_pkg::ST_MISS;
                        state_in  = osm_pkg::S_DONE;
                     end
                  end
                  default: begin
                     status_in = osm_pkg::ST_MISS;
                     state_in  = osm_pkg::S_DONE;
                  end
               endcase
            end
         end

         osm_pkg::S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[osm_pkg::ADDR_W-1:0];
               mid_in   = mid;
               state_in = osm_pkg::S_COMPARE;
            end else begin
               // Search finished: lo_ff is the position.
               case (func_ff)
                  osm_pkg::FUNC_INSERT: begin
                     if (lo_ff == count_ff) begin
                        state_in = osm_pkg::S_INS_PUT;
                     end else begin
                        rd_addr  = last_idx[osm_pkg::ADDR_W-1:0];
                        rd_in    = last_idx[osm_pkg::ADDR_W-1:0];
                        state_in = osm_pkg::S_INS_SHIFT;
                     end
                  end
                  osm_pkg::FUNC_DELETE: begin
                     if (lo_ff < count_ff) begin
                        rd_addr  = lo_ff[osm_pkg::ADDR_W-1:0];
                        state_in = osm_pkg::S_DEL_TEST;
                     end else begin
                        status_in = osm_pkg::ST_MISS;
                        state_in  = osm_pkg::S_DONE;
                     end
                  end
                  osm_pkg::FUNC_RANK: begin
                     answer_in = osm_pkg::DATA_W'(lo_ff) + 1'b1;
                     state_in  = osm_pkg::S_DONE;
                  end
                  osm_pkg::FUNC_PRED: begin
                     if (lo_ff != '0) begin
                        rd_addr  = osm_pkg::ADDR_W'(lo_ff - 1'b1);
                        state_in = osm_pkg::S_FETCH;
                     end else begin
                        status_in = osm_pkg::ST_MISS;
                        state_in  = osm_pkg::S_DONE;
                     end
                  end
                  osm_pkg::FUNC_SUCC: begin
                     if (lo_ff < count_ff) begin
                        rd_addr  = lo_ff[osm_pkg::ADDR_W-1:0];
                        state_in = osm_pkg::S_FETCH;
                     end else begin
                        status_in = osm_pkg::ST_MISS;
                        state_in  = osm_pkg::S_DONE;
                     end
                  end
                  default: begin
                     status_in = osm_pkg::ST_MISS;
                     state_in  = osm_pkg::S_DONE;
                  end
               endcase
            end
         end

         osm_pkg::S_COMPARE: begin
            if (lt || (le_ff && eq)) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = osm_pkg::S_SEARCH;
         end

         osm_pkg::S_FETCH: begin
            answer_in = rd_data;
            state_in  = osm_pkg::S_DONE;
         end

         osm_pkg::S_INS_SHIFT: begin
            // Move the entry read last cycle up by one, read the next one down.
            wr_en   = 1'b1;
            wr_addr = rd_ff + 1'b1;
            wr_data = rd_data;
            if (rd_ff == lo_ff[osm_pkg::ADDR_W-1:0]) begin
               state_in = osm_pkg::S_INS_PUT;
            end else begin
               rd_addr = rd_ff - 1'b1;
               rd_in   = rd_ff - 1'b1;
            end
         end

         osm_pkg::S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[osm_pkg::ADDR_W-1:0];
            wr_data  = val_ff;
            count_in = count_ff + 1'b1;
            state_in = osm_pkg::S_DONE;
         end

         osm_pkg::S_DEL_TEST: begin
            if (eq) begin
               if ((lo_ff + 1'b1) < count_ff) begin
                  rd_addr  = osm_pkg::ADDR_W'(lo_ff + 1'b1);
                  rd_in    = osm_pkg::ADDR_W'(lo_ff + 1'b1);
                  state_in = osm_pkg::S_DEL_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = osm_pkg::S_DONE;
               end
            end else begin
               status_in = osm_pkg::ST_MISS;
               state_in  = osm_pkg::S_DONE;
            end
         end

         osm_pkg::S_DEL_SHIFT: begin
            // Move the entry read last cycle down by one, read the next one up.
            wr_en   = 1'b1;
            wr_addr = rd_ff - 1'b1;
            wr_data = rd_data;
            if (rd_ff == last_idx[osm_pkg::ADDR_W-1:0]) begin
               count_in = count_ff - 1'b1;
               state_in = osm_pkg::S_DONE;
            end else begin
               rd_addr = rd_ff + 1'b1;
               rd_in   = rd_ff + 1'b1;
            end
         end

         osm_pkg::S_DONE: begin
            if (take) begin
               state_in = osm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = osm_pkg::S_IDLE;
         end
      endcase
   end

   assign idle          = state_ff == osm_pkg::S_IDLE;
   assign result.valid  = state_ff == osm_pkg::S_DONE;
   assign result.answer = answer_ff;
   assign result.status = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= osm_pkg::CNT_W'(osm_pkg::CAPACITY))
      else $error("element count above capacity");

   a_compare_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == osm_pkg::S_COMPARE) |-> (lo_ff < hi_ff))
      else $error("search compare with empty range");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == osm_pkg::S_INS_SHIFT || state_ff == osm_pkg::S_INS_PUT
                 || state_ff == osm_pkg::S_DEL_SHIFT))
      else $error("store written outside a shift or put");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == osm_pkg::S_INS_PUT) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not raise the count");

endmodule

// File: sv/order_statistic_multiset.sv
// Top level of the order statistic multiset: stream ports and result register.
// Depends on osm_pkg and osm_ctrl (which holds osm_ram).
`timescale 1ns / 1ps

// Usage:
// The block holds a sorted multiset of up to CAPACITY signed 32-bit values.
// One item on the req_ channel carries an operation in req_tuser (insert,
// delete, rank, select, predecessor, successor) and its operand in
// req_tdata. Every item produces exactly one item on the rsp_ channel with
// the answer in rsp_tdata and the status (ok, not found, store full) in
// rsp_tuser.
// One item is worked on at a time; req_tready is high only while the
// sequencer is idle. A query runs a binary search with one store read and
// one compare per search step. Insert and delete then move each stored
// entry above the position by one, one entry a cycle, since the store has
// a single write port. Select fetches the entry directly without a search;
// unknown operations go straight to a not-found result.
// A finished result goes into an output register, so a new item may be
// accepted while the previous result waits for rsp_tready. If the receiver
// stalls long enough, the next result stays in the sequencer and the block
// stops accepting until the register drains.
// Reset empties the multiset and drops any pending result; the store itself
// is not cleared, since only entries below the element count are read.
module order_statistic_multiset (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [osm_pkg::DATA_W-1:0]      req_tdata,  // [31:0] operand
   input  logic [osm_pkg::FUNC_W-1:0]      req_tuser,  // [2:0] func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [osm_pkg::DATA_W-1:0]      rsp_tdata,  // [31:0] answer
   output logic [osm_pkg::STATUS_W-1:0]    rsp_tuser   // [1:0] status
);

   osm_pkg::osm_result_type result;

   logic                         idle;
   logic                         start;
   logic                         take;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [osm_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [osm_pkg::STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;

   // The result moves into the output register when that register is empty
   // or is being emptied in this same cycle.
   assign take = result.valid && (!rsp_valid_ff || rsp_tready);

   osm_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .func    (req_tuser),
      .operand (req_tdata),
      .take    (take),
      .idle    (idle),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.answer;
         rsp_user_in  = result.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
